FILE: rtl/core/bat_pkg.sv
// Shared types, status codes and helpers for the buddy tree core.
`timescale 1ns / 1ps
package bat_pkg;

	localparam logic OP_CLAIM   = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_ZERO     = 3'd1;
	localparam logic [2:0] ST_NOSPACE  = 3'd2;
	localparam logic [2:0] ST_RANGE    = 3'd3;
	localparam logic [2:0] ST_NOTTAKEN = 3'd4;

	localparam logic REG_TOTAL = 1'b0;
	localparam logic REG_MIN   = 1'b1;

	localparam logic [4:0] TOTAL_RESET = 5'd16;
	localparam logic [4:0] MIN_RESET   = 5'd6;

	typedef enum logic [2:0] {
		S_REBUILD,
		S_IDLE,
		S_PREP,
		S_DESC,
		S_FIND,
		S_MARK,
		S_CLIMB,
		S_DONE
	} seq_state_t;

	// log2 of v rounded up; v of zero is handled by the caller
	function automatic logic [5:0] ceil_log2(input logic [31:0] v);
		logic [31:0] w;
		logic [5:0]  r;
		begin
			w = v - 32'd1;
			r = 6'd0;
			for (int i = 0; i < 32; i++) begin
				if (w[i]) r = 6'(i + 1);
			end
			return r;
		end
	endfunction

endpackage

FILE: rtl/core/bat_node_ram.sv
// Node store: one write port, two registered read ports.
`timescale 1ns / 1ps
module bat_node_ram #(
	parameter int DEPTH = 2047,
	parameter int AW    = 11
) (
	input  logic          clk,
	input  logic [AW-1:0] rd_addr_a,
	input  logic [AW-1:0] rd_addr_b,
	output logic [4:0]    rd_data_a,
	output logic [4:0]    rd_data_b,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [4:0]    wr_data
);

	logic [4:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_data_a <= mem[rd_addr_a];
		rd_data_b <= mem[rd_addr_b];
	end

endmodule

FILE: rtl/core/bat_seq.sv
// Request sequencer: rebuild sweep, descent, leaf climb and merge climb.
`timescale 1ns / 1ps
module bat_seq #(
	parameter int MAX_TREE_LEVELS = 10
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr,
	input  logic [4:0]                       eff_total,
	input  logic [4:0]                       eff_min,
	input  logic [$clog2(MAX_TREE_LEVELS+1)-1:0] eff_levels,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             operation,
	input  logic [31:0]                      request_size,
	input  logic [30:0]                      block_offset,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [2:0]                       status,
	output logic [30:0]                      result_offset,
	output logic [4:0]                       result_log2,
	output logic [MAX_TREE_LEVELS:0]         rd_addr_a,
	output logic [MAX_TREE_LEVELS:0]         rd_addr_b,
	input  logic [4:0]                       rd_data_a,
	input  logic [4:0]                       rd_data_b,
	output logic                             wr_en,
	output logic [MAX_TREE_LEVELS:0]         wr_addr,
	output logic [4:0]                       wr_data
);

	localparam int IW = MAX_TREE_LEVELS + 1;
	localparam int LW = $clog2(MAX_TREE_LEVELS + 1);
	localparam int PW = MAX_TREE_LEVELS;
	localparam logic [IW-1:0] LAST_NODE = IW'((2 ** IW) - 2);

	bat_pkg::seq_state_t state_q, state_d;

	logic          op_q;
	logic [31:0]   size_q;
	logic [30:0]   off_q;
	logic [4:0]    k_q;
	logic [IW-1:0] idx_q;
	logic [PW-1:0] pos_q;
	logic [4:0]    ns_q;
	logic [4:0]    wval_q;
	logic [2:0]    res_st_q;
	logic [30:0]   res_off_q;
	logic [4:0]    res_log_q;

	logic          out_valid_q;
	logic [2:0]    status_q;
	logic [30:0]   roff_q;
	logic [4:0]    rlog_q;

	logic [IW-1:0] rb_idx_q;
	logic [IW-1:0] rb_bnd_q;
	logic [LW-1:0] rb_lvl_q;
	logic [4:0]    rb_val;

	logic [5:0]    clog;
	logic          size_zero, no_space, out_range;
	logic [4:0]    kk;
	logic [PW-1:0] leaf_pos;
	logic [IW-1:0] leaf_idx;
	logic          lf, rf, go_right;
	logic [IW-1:0] nidx, par, sib_idx, sib_par;
	logic [PW-1:0] npos;
	logic [4:0]    ns_dn, pv, big;
	logic          load_out;

	assign clog      = bat_pkg::ceil_log2(size_q);
	assign size_zero = (size_q == 32'd0);
	assign no_space  = (rd_data_a == 5'd0) || (clog > {1'b0, rd_data_a});
	assign kk        = (clog[4:0] > eff_min) ? clog[4:0] : eff_min;
	assign out_range = ((32'(off_q) >> eff_total) != 32'd0);
	assign leaf_pos  = PW'(off_q >> eff_min);
	assign leaf_idx  = IW'(leaf_pos) + ((IW'(1) << eff_levels) - IW'(1));

	// pick the fitting child, smaller mark first, left on a tie
	assign lf       = (rd_data_a >= k_q);
	assign rf       = (rd_data_b >= k_q);
	assign go_right = (lf && rf) ? (rd_data_a > rd_data_b) : !lf;
	assign nidx     = (idx_q << 1) + IW'(1) + IW'(go_right);
	assign npos     = (pos_q << 1) | PW'(go_right);
	assign ns_dn    = ns_q - 5'd1;

	assign par     = (idx_q - IW'(1)) >> 1;
	assign sib_idx = idx_q[0] ? idx_q + IW'(1) : idx_q - IW'(1);
	assign sib_par = par[0] ? par + IW'(1) : par - IW'(1);

	// parent mark: merge when both halves are wholly free
	assign big = (wval_q >= rd_data_a) ? wval_q : rd_data_a;
	assign pv  = (wval_q == ns_q && rd_data_a == ns_q) ? ns_q + 5'd1 : big;

	assign rb_val = (rb_lvl_q <= eff_levels) ? eff_total - 5'(rb_lvl_q) : 5'd0;

	assign load_out = (state_q == bat_pkg::S_DONE) && (!out_valid_q || !out_stall);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			bat_pkg::S_REBUILD: begin
				if (rb_idx_q == LAST_NODE) state_d = bat_pkg::S_IDLE;
			end
			bat_pkg::S_IDLE: begin
				if (in_valid) state_d = bat_pkg::S_PREP;
			end
			bat_pkg::S_PREP: begin
				if (op_q == bat_pkg::OP_CLAIM) begin
					if (size_zero || no_space) state_d = bat_pkg::S_DONE;
					else if (eff_total > kk) state_d = bat_pkg::S_DESC;
					else state_d = bat_pkg::S_MARK;
				end else begin
					state_d = out_range ? bat_pkg::S_DONE : bat_pkg::S_FIND;
				end
			end
			bat_pkg::S_DESC: begin
				if (ns_dn <= k_q) state_d = bat_pkg::S_MARK;
			end
			bat_pkg::S_FIND: begin
				if (rd_data_a == 5'd0) state_d = bat_pkg::S_MARK;
				else if (idx_q == '0) state_d = bat_pkg::S_DONE;
			end
			bat_pkg::S_MARK: begin
				state_d = (idx_q == '0) ? bat_pkg::S_DONE : bat_pkg::S_CLIMB;
			end
			bat_pkg::S_CLIMB: begin
				if (par == '0) state_d = bat_pkg::S_DONE;
			end
			bat_pkg::S_DONE: begin
				if (load_out) state_d = bat_pkg::S_IDLE;
			end
			default: state_d = bat_pkg::S_REBUILD;
		endcase
		if (cfg_wr) state_d = bat_pkg::S_REBUILD;
	end

	// memory ports and handshake
	always_comb begin
		in_stall  = (state_q != bat_pkg::S_IDLE);
		rd_addr_a = '0;
		rd_addr_b = '0;
		wr_en     = 1'b0;
		wr_addr   = idx_q;
		wr_data   = wval_q;
		case (state_q)
			bat_pkg::S_REBUILD: begin
				wr_en   = 1'b1;
				wr_addr = rb_idx_q;
				wr_data = rb_val;
			end
			bat_pkg::S_PREP: begin
				if (op_q == bat_pkg::OP_CLAIM) begin
					rd_addr_a = IW'(1);
					rd_addr_b = IW'(2);
				end else begin
					rd_addr_a = leaf_idx;
				end
			end
			bat_pkg::S_DESC: begin
				rd_addr_a = (nidx << 1) + IW'(1);
				rd_addr_b = (nidx << 1) + IW'(2);
			end
			bat_pkg::S_FIND: begin
				rd_addr_a = par;
			end
			bat_pkg::S_MARK: begin
				wr_en     = 1'b1;
				rd_addr_a = sib_idx;
			end
			bat_pkg::S_CLIMB: begin
				wr_en     = 1'b1;
				wr_addr   = par;
				wr_data   = pv;
				rd_addr_a = sib_par;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bat_pkg::S_REBUILD;
			out_valid_q <= 1'b0;
			rb_idx_q    <= '0;
			rb_bnd_q    <= IW'(1);
			rb_lvl_q    <= '0;
		end else begin
			state_q <= state_d;
			if (load_out) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			if (cfg_wr) begin
				rb_idx_q <= '0;
				rb_bnd_q <= IW'(1);
				rb_lvl_q <= '0;
			end else if (state_q == bat_pkg::S_REBUILD && rb_idx_q != LAST_NODE) begin
				rb_idx_q <= rb_idx_q + IW'(1);
				if (rb_idx_q + IW'(1) == rb_bnd_q) begin
					rb_lvl_q <= rb_lvl_q + LW'(1);
					rb_bnd_q <= (rb_bnd_q << 1) + IW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			status_q <= res_st_q;
			roff_q   <= res_off_q;
			rlog_q   <= res_log_q;
		end
		case (state_q)
			bat_pkg::S_IDLE: begin
				op_q   <= operation;
				size_q <= request_size;
				off_q  <= block_offset;
			end
			bat_pkg::S_PREP: begin
				res_st_q  <= bat_pkg::ST_OK;
				res_off_q <= '0;
				res_log_q <= '0;
				wval_q    <= '0;
				if (op_q == bat_pkg::OP_CLAIM) begin
					if (size_zero) res_st_q <= bat_pkg::ST_ZERO;
					else if (no_space) res_st_q <= bat_pkg::ST_NOSPACE;
					k_q   <= kk;
					idx_q <= '0;
					pos_q <= '0;
					ns_q  <= eff_total;
				end else begin
					if (out_range) res_st_q <= bat_pkg::ST_RANGE;
					idx_q <= leaf_idx;
					pos_q <= leaf_pos;
					ns_q  <= eff_min;
				end
			end
			bat_pkg::S_DESC: begin
				idx_q <= nidx;
				pos_q <= npos;
				ns_q  <= ns_dn;
			end
			bat_pkg::S_FIND: begin
				if (rd_data_a != 5'd0) begin
					if (idx_q == '0) res_st_q <= bat_pkg::ST_NOTTAKEN;
					idx_q <= par;
					pos_q <= pos_q >> 1;
					ns_q  <= ns_q + 5'd1;
				end else begin
					wval_q <= ns_q;
				end
			end
			bat_pkg::S_MARK: begin
				res_off_q <= 31'(pos_q) << ns_q;
				res_log_q <= ns_q;
			end
			bat_pkg::S_CLIMB: begin
				idx_q  <= par;
				ns_q   <= ns_q + 5'd1;
				wval_q <= pv;
			end
			default: begin
			end
		endcase
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign result_offset = roff_q;
	assign result_log2   = rlog_q;

endmodule

FILE: rtl/core/buddy_allocator_tree_core.sv
// Top level: configuration registers, node store and request sequencer.
`timescale 1ns / 1ps
// An early error goes straight to the result; a claim descends the levels to its block and a
//   release climbs from its leaf to the allocated block; any block found then has its
//   ancestors repaired.
// Throughput: one request at a time; each level costs one read of the node store going
//   down (or up to the block) and one write and one read while climbing.
// Reset and every configuration write start a rebuild sweep over 2^(MAX_TREE_LEVELS+1)-1
//   nodes (2047 by default), one node a cycle, during which no request is taken.
module buddy_allocator_tree_core #(
	parameter int MAX_TREE_LEVELS = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_wr_en,
	input  logic        cfg_index,
	input  logic [4:0]  cfg_wdata,
	// request channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        operation,
	input  logic [31:0] request_size,
	input  logic [30:0] block_offset,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [30:0] result_offset,
	output logic [4:0]  result_log2
);

	localparam int IW    = MAX_TREE_LEVELS + 1;
	localparam int DEPTH = (2 ** IW) - 1;
	localparam int LW    = $clog2(MAX_TREE_LEVELS + 1);
	localparam logic [4:0] MAXL = 5'(MAX_TREE_LEVELS);

	logic [4:0] total_q, minb_q;
	logic [4:0] t_eff, m_one, m_cap, m_eff;
	logic [LW-1:0] levels;

	logic [IW-1:0] rd_addr_a, rd_addr_b, wr_addr;
	logic [4:0]    rd_data_a, rd_data_b, wr_data;
	logic          wr_en;

	// Hold the raw register values; the sequencer restarts its sweep on any transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= bat_pkg::TOTAL_RESET;
			minb_q  <= bat_pkg::MIN_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				bat_pkg::REG_TOTAL: total_q <= cfg_wdata;
				bat_pkg::REG_MIN:   minb_q  <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// Clamp the geometry: zero reads as one, minimum never above total,
	// and raise the minimum when the tree would get too deep.
	assign t_eff  = (total_q == 5'd0) ? 5'd1 : total_q;
	assign m_one  = (minb_q == 5'd0) ? 5'd1 : minb_q;
	assign m_cap  = (m_one > t_eff) ? t_eff : m_one;
	assign m_eff  = (t_eff - m_cap > MAXL) ? t_eff - MAXL : m_cap;
	assign levels = LW'(t_eff - m_eff);

	bat_node_ram #(
		.DEPTH(DEPTH),
		.AW   (IW)
	) u_ram (
		.clk      (clk),
		.rd_addr_a(rd_addr_a),
		.rd_addr_b(rd_addr_b),
		.rd_data_a(rd_data_a),
		.rd_data_b(rd_data_b),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data)
	);

	// Walk the tree: descend to claim, climb to release, then repair ancestors.
	bat_seq #(
		.MAX_TREE_LEVELS(MAX_TREE_LEVELS)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr       (cfg_wr_en),
		.eff_total    (t_eff),
		.eff_min      (m_eff),
		.eff_levels   (levels),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.operation    (operation),
		.request_size (request_size),
		.block_offset (block_offset),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.result_offset(result_offset),
		.result_log2  (result_log2),
		.rd_addr_a    (rd_addr_a),
		.rd_addr_b    (rd_addr_b),
		.rd_data_a    (rd_data_a),
		.rd_data_b    (rd_data_b),
		.wr_en        (wr_en),
		.wr_addr      (wr_addr),
		.wr_data      (wr_data)
	);

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for the buddy allocator tree core.
`timescale 1ns / 1ps
module testbench;

	localparam int TREE_LEVELS = 10;
	localparam int NODES       = (2 << TREE_LEVELS) - 1;
	localparam int IDLE_LIMIT  = 20000;

	typedef struct packed {
		logic [2:0]  st;
		logic [30:0] off;
		logic [4:0]  lg;
	} result_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic        cfg_index;
	logic [4:0]  cfg_wdata;
	logic        in_valid;
	logic        in_stall;
	logic        operation;
	logic [31:0] request_size;
	logic [30:0] block_offset;
	logic        out_valid;
	logic        out_stall;
	logic [2:0]  status;
	logic [30:0] result_offset;
	logic [4:0]  result_log2;

	buddy_allocator_tree_core #(.MAX_TREE_LEVELS(TREE_LEVELS)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .operation(operation),
		.request_size(request_size), .block_offset(block_offset),
		.out_valid(out_valid), .out_stall(out_stall), .status(status),
		.result_offset(result_offset), .result_log2(result_log2)
	);

	always begin
		clk = 1'b0; #10;
		clk = 1'b1; #10;
	end

	// Mirror of the free-size tree and the active geometry.
	logic [4:0]      size_tree [0:NODES-1];
	logic [4:0]      reg_total, reg_min;
	int unsigned     geo_total, geo_min, geo_levels;
	result_t         pending_q [$];
	longint unsigned live_blocks [$];
	int              errors;
	int              hold_cycles;   // long receiver hold-off requested by a test
	bit              burst;         // sender offers back to back
	bit              first_item;

	function automatic void rebuild_tree();
		int unsigned t, m;
		t = reg_total;
		m = reg_min;
		if (t < 1) t = 1;
		if (m < 1) m = 1;
		if (m > t) m = t;
		if (t - m > TREE_LEVELS) m = t - TREE_LEVELS;
		geo_total  = t;
		geo_min    = m;
		geo_levels = t - m;
		for (int i = 0; i < NODES; i++) size_tree[i] = '0;
		for (int d = 0; d <= geo_levels; d++)
			for (int i = (1 << d) - 1; i <= (2 << d) - 2; i++) size_tree[i] = 5'(t - d);
		live_blocks.delete();
	endfunction

	function automatic longint unsigned block_start(int unsigned idx, int unsigned ns);
		int unsigned d, v;
		d = 0;
		v = idx + 1;
		while (v > 1) begin
			v >>= 1;
			d++;
		end
		return longint'(idx + 1 - (1 << d)) << ns;
	endfunction

	function automatic logic [4:0] wider_child(int unsigned p);
		logic [4:0] l, r;
		l = size_tree[2*p+1];
		r = size_tree[2*p+2];
		return (l >= r) ? l : r;
	endfunction

	function automatic result_t claim_block(logic [31:0] size);
		int unsigned k, idx, ns;
		logic [4:0] l, r;
		result_t res;
		res = '0;
		k = geo_min;
		idx = 0;
		ns = geo_total;
		if (size == 0) begin
			res.st = bat_pkg::ST_ZERO;
			return res;
		end
		if (size_tree[0] == 0 || 64'(size) > (64'd1 << size_tree[0])) begin
			res.st = bat_pkg::ST_NOSPACE;
			return res;
		end
		while (k < 31 && (64'd1 << k) < 64'(size)) k++;
		while (ns > k) begin
			l = size_tree[2*idx+1];
			r = size_tree[2*idx+2];
			if (l >= k && r >= k) idx = (l <= r) ? 2*idx + 1 : 2*idx + 2;
			else if (l >= k) idx = 2*idx + 1;
			else idx = 2*idx + 2;
			ns--;
		end
		res.st  = bat_pkg::ST_OK;
		res.off = 31'(block_start(idx, ns));
		res.lg  = 5'(ns);
		size_tree[idx] = '0;
		while (idx != 0) begin
			idx = (idx - 1) >> 1;
			size_tree[idx] = wider_child(idx);
		end
		return res;
	endfunction

	function automatic result_t release_block(logic [30:0] off);
		int unsigned idx, ns;
		result_t res;
		res = '0;
		if (64'(off) >= (64'd1 << geo_total)) begin
			res.st = bat_pkg::ST_RANGE;
			return res;
		end
		idx = (int'(off) >> geo_min) + (1 << geo_levels) - 1;
		ns = geo_min;
		while (size_tree[idx] != 0) begin
			if (idx == 0) begin
				res.st = bat_pkg::ST_NOTTAKEN;
				return res;
			end
			ns++;
			idx = (idx - 1) >> 1;
		end
		res.st  = bat_pkg::ST_OK;
		res.off = 31'(block_start(idx, ns));
		res.lg  = 5'(ns);
		size_tree[idx] = 5'(ns);
		while (idx != 0) begin
			ns++;
			idx = (idx - 1) >> 1;
			if (size_tree[2*idx+1] == ns - 1 && size_tree[2*idx+2] == ns - 1)
				size_tree[idx] = 5'(ns);
			else
				size_tree[idx] = wider_child(idx);
		end
		return res;
	endfunction

	// Offer one request, hold it until the transfer, then predict its result.
	task automatic send_request(logic op, logic [31:0] size, logic [30:0] off);
		int gap;
		result_t res;
		gap = (burst || first_item || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		operation    <= op;
		request_size <= size;
		block_offset <= off;
		first_item = 1'b0;
		do @(posedge clk); while (in_stall);
		if (op == bat_pkg::OP_CLAIM) begin
			res = claim_block(size);
			if (res.st == bat_pkg::ST_OK) live_blocks.push_back(res.off);
		end else begin
			res = release_block(off);
			if (res.st == bat_pkg::ST_OK)
				foreach (live_blocks[i])
					if (live_blocks[i] == res.off) begin
						live_blocks.delete(i);
						break;
					end
		end
		pending_q.push_back(res);
	endtask

	// Drop valid and let every expected result come home.
	task automatic drain();
		in_valid <= 1'b0;
		first_item = 1'b1;
		@(posedge clk);
		while (pending_q.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	// Write one register while the block is idle; it rebuilds the tree afterwards.
	task automatic write_reg(logic idx, logic [4:0] value);
		drain();
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == bat_pkg::REG_TOTAL) reg_total = value;
		else reg_min = value;
		rebuild_tree();
	endtask

	task automatic set_geometry(logic [4:0] total, logic [4:0] minimum);
		write_reg(bat_pkg::REG_TOTAL, total);
		write_reg(bat_pkg::REG_MIN, minimum);
	endtask

	// Directed checks on the reset geometry: zero size, rounding, field extremes.
	task automatic test_reset_geometry();
		send_request(bat_pkg::OP_CLAIM, 32'd0, '0);
		send_request(bat_pkg::OP_CLAIM, 32'd1, '0);
		send_request(bat_pkg::OP_CLAIM, 32'd65, '0);
		send_request(bat_pkg::OP_CLAIM, 32'h8000_0000, '0);
		send_request(bat_pkg::OP_CLAIM, 32'hFFFF_FFFF, '0);
		send_request(bat_pkg::OP_RELEASE, 32'hFFFF_FFFF, 31'd130); // inside the 128-byte block
		send_request(bat_pkg::OP_RELEASE, '0, 31'd65536);          // just past the region
		send_request(bat_pkg::OP_RELEASE, '0, 31'h7FFF_FFFF);
		send_request(bat_pkg::OP_RELEASE, '0, 31'd4096);           // never claimed
		send_request(bat_pkg::OP_CLAIM, 32'd65536, '0);
		send_request(bat_pkg::OP_CLAIM, 32'd64, '0);               // the whole-region claim above fails, this one still fits
		send_request(bat_pkg::OP_RELEASE, '0, 31'd0);
	endtask

	// Small region: fill it, hit the full check, then merge buddies back.
	task automatic test_fill_and_merge();
		set_geometry(5'd8, 5'd6);
		for (int i = 0; i < 4; i++) send_request(bat_pkg::OP_CLAIM, 32'd64, '0);
		send_request(bat_pkg::OP_CLAIM, 32'd1, '0);
		for (int i = 0; i < 4; i++) send_request(bat_pkg::OP_RELEASE, '0, 31'(i * 64 + 63));
		send_request(bat_pkg::OP_CLAIM, 32'd256, '0);
		send_request(bat_pkg::OP_CLAIM, 32'd257, '0);
	endtask

	// Degenerate register values: zero total and minimum, minimum above total,
	// and a span deeper than the tree.
	task automatic test_clamped_geometry();
		set_geometry(5'd0, 5'd0);
		send_request(bat_pkg::OP_CLAIM, 32'd2, '0);
		send_request(bat_pkg::OP_CLAIM, 32'd1, '0);
		send_request(bat_pkg::OP_RELEASE, '0, 31'd1);
		set_geometry(5'd3, 5'd20);
		send_request(bat_pkg::OP_CLAIM, 32'd5, '0);
		send_request(bat_pkg::OP_RELEASE, '0, 31'd8);
		set_geometry(5'd31, 5'd1);
		send_request(bat_pkg::OP_CLAIM, 32'h8000_0000, '0);
		send_request(bat_pkg::OP_RELEASE, '0, 31'h7FFF_FFFF);
		send_request(bat_pkg::OP_CLAIM, 32'h8000_0001, '0);
	endtask

	// Mostly well-formed claim/release traffic over several geometries.
	task automatic test_random_traffic();
		logic [4:0] totals [6] = '{5'd16, 5'd31, 5'd12, 5'd5, 5'd20, 5'd31};
		logic [4:0] mins   [6] = '{5'd6, 5'd21, 5'd2, 5'd5, 5'd12, 5'd31};
		int unsigned e, pick, roll;
		longint unsigned off;
		foreach (totals[s]) begin
			set_geometry(totals[s], mins[s]);
			for (int n = 0; n < 165; n++) begin
				roll = $urandom_range(0, 99);
				if (roll < 15) begin
					// noise: raw fields over their whole width
					case ($urandom_range(0, 2))
						0: send_request(bat_pkg::OP_CLAIM, $urandom, '0);
						1: send_request(bat_pkg::OP_RELEASE, $urandom, 31'($urandom));
						default: send_request(bat_pkg::OP_CLAIM, 32'd0, 31'($urandom));
					endcase
				end else if (roll < 60 || live_blocks.size() == 0) begin
					e = $urandom_range(0, geo_total > geo_min + 3 ? geo_min + 3 : geo_total);
					if ($urandom_range(0, 9) == 0) e = $urandom_range(0, geo_total);
					send_request(bat_pkg::OP_CLAIM, $urandom_range(1, 32'd1 << e),
						31'($urandom));
				end else begin
					pick = $urandom_range(0, live_blocks.size() - 1);
					off = live_blocks[pick] + $urandom_range(0, (1 << geo_min) - 1);
					send_request(bat_pkg::OP_RELEASE, $urandom, 31'(off));
				end
			end
			// pause the sender until the block has answered everything
			if (s == 2) drain();
		end
	endtask

	// Long receiver hold-off while the sender keeps offering back to back.
	task automatic test_backpressure();
		set_geometry(5'd14, 5'd6);
		hold_cycles = 400;
		burst = 1'b1;
		for (int n = 0; n < 40; n++)
			send_request(n % 3 == 2 ? bat_pkg::OP_RELEASE : bat_pkg::OP_CLAIM,
				$urandom_range(1, 2048), 31'($urandom_range(0, 16383)));
		burst = 1'b0;
		drain();
	endtask

	// Result side: random stall per transfer, compare against the oldest expectation.
	initial begin
		int rx_wait;
		result_t want;
		out_stall = 1'b0;
		rx_wait = 0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				if (pending_q.size() == 0) begin
					$error("result transfer with nothing expected");
					errors++;
				end else begin
					want = pending_q.pop_front();
					if (status !== want.st) begin
						$error("status expected %0d actual %0d", want.st, status);
						errors++;
					end
					if (result_offset !== want.off) begin
						$error("result_offset expected %0h actual %0h", want.off, result_offset);
						errors++;
					end
					if (result_log2 !== want.lg) begin
						$error("result_log2 expected %0d actual %0d", want.lg, result_log2);
						errors++;
					end
				end
				rx_wait = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
			end
			if (hold_cycles > 0) begin
				out_stall <= 1'b1;
				hold_cycles--;
			end else if (rx_wait > 0) begin
				out_stall <= 1'b1;
				rx_wait--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Watchdog: end the run if no transfer happens on either channel for too long.
	initial begin
		int idle;
		idle = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle = 0;
			else idle++;
			if (idle >= IDLE_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin
		errors       = 0;
		hold_cycles  = 0;
		burst        = 1'b0;
		first_item   = 1'b1;
		arst_n       = 1'b0;
		cfg_wr_en    = 1'b0;
		cfg_index    = bat_pkg::REG_TOTAL;
		cfg_wdata    = '0;
		in_valid     = 1'b0;
		operation    = bat_pkg::OP_CLAIM;
		request_size = '0;
		block_offset = '0;
		reg_total    = bat_pkg::TOTAL_RESET;
		reg_min      = bat_pkg::MIN_RESET;
		rebuild_tree();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_geometry();
		test_fill_and_merge();
		test_clamped_geometry();
		test_random_traffic();
		test_backpressure();
		drain();

		if (errors == 0 && pending_q.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
